>>> hw/rtl/pedestal_add_pixel_binning_macros.svh
// Assertion macros shared by the pixel binning RTL.
`ifndef PEDESTAL_ADD_PIXEL_BINNING_MACROS_SVH
`define PEDESTAL_ADD_PIXEL_BINNING_MACROS_SVH

`ifndef SYNTHESIS

// Checks that a condition implies another one at the same clock edge.
`define PAB_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("assertion failed: same-cycle implication");

// Checks that a condition implies another one at the next clock edge.
`define PAB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("assertion failed: next-cycle implication");

`else

`define PAB_ASSERT_IMPLY(label, ante, cons)
`define PAB_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> hw/rtl/pab_pkg.sv
// Package with item types, configuration codes and constants of the pixel binner.
`default_nettype none

package pab_pkg;

    localparam int CORR_W  = 19;
    localparam int SUM_W   = 25;
    localparam int COORD_W = 12;
    localparam int CFG_W   = 13;

    localparam logic [CORR_W-1:0] FIXED_OFFSET = 19'h10000;
    localparam logic [SUM_W-1:0]  SUM_MAX      = 25'h1FFFFFF;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FRAME_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_BIN_FACTOR    = 2'd2;
    localparam logic [1:0] CFG_PEDESTAL_MODE = 2'd3;

    typedef struct packed {
        logic [15:0] pixel_value;
        logic [17:0] pedestal_value;
        logic        frame_start;
    } t_in_item;

    typedef struct packed {
        logic [SUM_W-1:0]   bin_sum;
        logic [COORD_W-1:0] bin_column;
        logic [COORD_W-1:0] bin_row;
        logic               frame_last;
    } t_out_item;

    typedef struct packed {
        logic [CFG_W-1:0] frame_width;
        logic [CFG_W-1:0] frame_height;
        logic [3:0]       bin_factor;
        logic             pedestal_mode;
    } t_cfg;

    // Per-pixel control handed from the position stage to the accumulator.
    typedef struct packed {
        logic                first;
        logic                emit;
        logic                frame_last;
        logic [COORD_W-1:0]  bin_column;
        logic [COORD_W-1:0]  bin_row;
        logic [CORR_W-1:0]   corrected;
    } t_pos_info;

endpackage

`default_nettype wire

>>> hw/rtl/pab_position.sv
// Position counters, bin boundary decisions and pedestal correction for each pixel.
`default_nettype none

module pab_position #(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_BIN   = 8,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int BW = (MAX_BIN > 1) ? $clog2(MAX_BIN) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire pab_pkg::t_in_item i_item,
    input  wire pab_pkg::t_cfg     i_cfg,
    output pab_pkg::t_pos_info     o_info,
    output logic [CW-1:0]          o_idx
);
    import pab_pkg::*;

    logic [CW-1:0] r_pixel_column, n_pixel_column;
    logic [CW-1:0] r_pixel_row, n_pixel_row;
    logic [BW-1:0] r_column_in_bin, n_column_in_bin;
    logic [BW-1:0] r_row_in_bin, n_row_in_bin;
    logic [CW-1:0] r_bin_column, n_bin_column;
    logic [CW-1:0] r_bin_row, n_bin_row;

    logic [CW-1:0] col, row, bcol, brow;
    logic [BW-1:0] cib, rib;
    logic [CW-1:0] last_col, last_row;
    logic [BW-1:0] last_bin;
    logic          row_end, frame_end, bin_col_end, bin_row_end;

    // Clamp the configured sizes to their legal ranges and take the last index.
    always_comb begin
        if (i_cfg.frame_width == '0) begin
            last_col = '0;
        end else if (32'(i_cfg.frame_width) > MAX_WIDTH) begin
            last_col = CW'(MAX_WIDTH - 1);
        end else begin
            last_col = CW'(i_cfg.frame_width - 13'd1);
        end
        if (i_cfg.frame_height == '0) begin
            last_row = '0;
        end else if (32'(i_cfg.frame_height) > MAX_WIDTH) begin
            last_row = CW'(MAX_WIDTH - 1);
        end else begin
            last_row = CW'(i_cfg.frame_height - 13'd1);
        end
        if (i_cfg.bin_factor == '0) begin
            last_bin = '0;
        end else if (32'(i_cfg.bin_factor) > MAX_BIN) begin
            last_bin = BW'(MAX_BIN - 1);
        end else begin
            last_bin = BW'(i_cfg.bin_factor - 4'd1);
        end
    end

    // A frame start clears the position before this pixel is placed.
    assign col  = i_item.frame_start ? '0 : r_pixel_column;
    assign row  = i_item.frame_start ? '0 : r_pixel_row;
    assign cib  = i_item.frame_start ? '0 : r_column_in_bin;
    assign rib  = i_item.frame_start ? '0 : r_row_in_bin;
    assign bcol = i_item.frame_start ? '0 : r_bin_column;
    assign brow = i_item.frame_start ? '0 : r_bin_row;

    assign row_end     = col >= last_col;
    assign frame_end   = row >= last_row;
    assign bin_col_end = row_end || (cib >= last_bin);
    assign bin_row_end = frame_end || (rib >= last_bin);

    // Control for the accumulator stage.
    always_comb begin
        o_info.first      = (cib == '0) && (rib == '0);
        o_info.emit       = bin_col_end && bin_row_end;
        o_info.frame_last = row_end && frame_end;
        o_info.bin_column = COORD_W'(bcol);
        o_info.bin_row    = COORD_W'(brow);
        o_info.corrected  = CORR_W'(i_item.pixel_value)
                          + (i_cfg.pedestal_mode ? CORR_W'(i_item.pedestal_value)
                                                 : FIXED_OFFSET);
    end

    assign o_idx = bcol;

    // Advance the raster and bin counters.
    always_comb begin
        n_pixel_column  = r_pixel_column;
        n_pixel_row     = r_pixel_row;
        n_column_in_bin = r_column_in_bin;
        n_row_in_bin    = r_row_in_bin;
        n_bin_column    = r_bin_column;
        n_bin_row       = r_bin_row;
        if (i_step) begin
            n_pixel_row  = row;
            n_row_in_bin = rib;
            n_bin_row    = brow;
            if (row_end) begin
                n_pixel_column  = '0;
                n_column_in_bin = '0;
                n_bin_column    = '0;
                if (frame_end) begin
                    n_pixel_row  = '0;
                    n_row_in_bin = '0;
                    n_bin_row    = '0;
                end else begin
                    n_pixel_row = row + 1'b1;
                    if (bin_row_end) begin
                        n_row_in_bin = '0;
                        n_bin_row    = brow + 1'b1;
                    end else begin
                        n_row_in_bin = rib + 1'b1;
                    end
                end
            end else begin
                n_pixel_column = col + 1'b1;
                if (bin_col_end) begin
                    n_column_in_bin = '0;
                    n_bin_column    = bcol + 1'b1;
                end else begin
                    n_column_in_bin = cib + 1'b1;
                    n_bin_column    = bcol;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_column  <= '0;
            r_pixel_row     <= '0;
            r_column_in_bin <= '0;
            r_row_in_bin    <= '0;
            r_bin_column    <= '0;
            r_bin_row       <= '0;
        end else begin
            r_pixel_column  <= n_pixel_column;
            r_pixel_row     <= n_pixel_row;
            r_column_in_bin <= n_column_in_bin;
            r_row_in_bin    <= n_row_in_bin;
            r_bin_column    <= n_bin_column;
            r_bin_row       <= n_bin_row;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/pab_accum.sv
// Row store of partial bin sums with read-modify-write, forwarding and saturation.
`default_nettype none

module pab_accum #(
    parameter int MAX_WIDTH = 4096,
    localparam int CW = $clog2(MAX_WIDTH)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire pab_pkg::t_pos_info i_info,
    input  wire logic [CW-1:0]      i_idx,
    output logic                    o_valid,
    output pab_pkg::t_out_item      o_item
);
    import pab_pkg::*;

    logic [SUM_W-1:0] r_mem [MAX_WIDTH];
    logic [SUM_W-1:0] r_rd;
    logic             r_s2_valid;
    t_pos_info        r_s2_info;
    logic [CW-1:0]    r_s2_idx;
    logic             r_fwd_valid;
    logic [SUM_W-1:0] r_fwd_data;

    logic [SUM_W-1:0] base;
    logic [SUM_W:0]   sum_wide;
    logic [SUM_W-1:0] sum;
    logic             wr_en;

    // The store still holds the old value when the previous pixel wrote the
    // same entry on the read edge, so that sum is taken from the bypass.
    assign base     = r_fwd_valid ? r_fwd_data : r_rd;
    assign sum_wide = {1'b0, base} + (SUM_W + 1)'(r_s2_info.corrected);

    always_comb begin
        if (r_s2_info.first) begin
            sum = SUM_W'(r_s2_info.corrected);
        end else if (sum_wide > (SUM_W + 1)'(SUM_MAX)) begin
            sum = SUM_MAX;
        end else begin
            sum = SUM_W'(sum_wide);
        end
    end

    assign wr_en = i_en && r_s2_valid;

    // Row store: one read and one write per cycle.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_s2_idx] <= sum;
        end
        if (i_en && i_valid) begin
            r_rd <= r_mem[i_idx];
        end
    end

    // Second stage payload and bypass data.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_info  <= i_info;
            r_s2_idx   <= i_idx;
            r_fwd_data <= sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else if (i_en) begin
            r_s2_valid  <= i_valid;
            r_fwd_valid <= r_s2_valid && (r_s2_idx == i_idx);
        end
    end

    // Finished bin toward the output register.
    assign o_valid           = r_s2_valid && r_s2_info.emit;
    assign o_item.bin_sum    = sum;
    assign o_item.bin_column = r_s2_info.bin_column;
    assign o_item.bin_row    = r_s2_info.bin_row;
    assign o_item.frame_last = r_s2_info.frame_last;

endmodule

`default_nettype wire

>>> hw/rtl/pedestal_add_pixel_binning.sv
// A result passes through the input register, the accumulator's second stage and the output register.
// Throughput: one pixel per cycle when not stalled; one store read and write per cycle.
// While a result waits under stall, the whole pipeline holds and no pixel is taken.
// Reset (synchronous, active low) clears counters and valids and loads register defaults.
// The row store is not cleared; each bin overwrites its entry on its first pixel.
`default_nettype none

`include "pedestal_add_pixel_binning_macros.svh"

module pedestal_add_pixel_binning #(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_BIN   = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire pab_pkg::t_in_item  i_in_data,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    output pab_pkg::t_out_item      o_out_data,
    input  wire logic               i_out_stall,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [12:0]        i_cfg_data
);
    import pab_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    t_cfg          r_cfg;
    logic          r_in_valid;
    t_in_item      r_in;
    logic          r_out_valid;
    t_out_item     r_out;
    logic          en;
    t_pos_info     pos_info;
    logic [CW-1:0] pos_idx;
    logic          res_valid;
    t_out_item     res_item;

    // The pipeline advances unless a finished result is held by the sink.
    assign en          = !(r_out_valid && i_out_stall);
    assign o_in_stall  = !en;
    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width   <= 13'd1024;
            r_cfg.frame_height  <= 13'd1024;
            r_cfg.bin_factor    <= 4'd1;
            r_cfg.pedestal_mode <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:   r_cfg.frame_width   <= i_cfg_data;
                CFG_FRAME_HEIGHT:  r_cfg.frame_height  <= i_cfg_data;
                CFG_BIN_FACTOR:    r_cfg.bin_factor    <= 4'(i_cfg_data);
                CFG_PEDESTAL_MODE: r_cfg.pedestal_mode <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    pab_position #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_BIN   (MAX_BIN)
    ) u_position (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (en && r_in_valid),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_info  (pos_info),
        .o_idx   (pos_idx)
    );

    pab_accum #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_in_valid),
        .i_info  (pos_info),
        .i_idx   (pos_idx),
        .o_valid (res_valid),
        .o_item  (res_item)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && res_valid) begin
            r_out <= res_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A held result freezes the input side.
    `PAB_ASSERT_IMPLY(a_freeze_on_stall, r_out_valid && i_out_stall, o_in_stall)
    // A finished bin in the accumulator reaches the output register.
    `PAB_ASSERT_NEXT(a_result_loaded, en && res_valid, r_out_valid)
    // An accepted pixel is in the input register on the next cycle.
    `PAB_ASSERT_NEXT(a_input_captured, i_in_valid && !o_in_stall, r_in_valid)

endmodule

`default_nettype wire

>>> bench/pab_bin_checker.sv
// Checker that watches the pixel binner's channels, predicts each bin and compares.
`timescale 1ns / 100ps

module pab_bin_checker #(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_BIN   = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire pab_pkg::t_in_item  i_in_data,
    input  wire logic               i_in_stall,
    input  wire logic               i_out_valid,
    input  wire pab_pkg::t_out_item i_out_data,
    input  wire logic               i_out_stall,
    input  wire logic               i_cfg_valid,
    input  wire logic               i_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [12:0]        i_cfg_data,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_bin_count
);
    import pab_pkg::*;

    localparam int PRINT_CAP = 40;
    localparam int IDX_W     = $clog2(MAX_WIDTH);

    // Shadow copy of the configuration registers.
    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    logic [3:0]         bin_reg;
    logic               mode_reg;

    // Shadow copy of the position counters and the row store of partial sums.
    logic [COORD_W-1:0] pix_col;
    logic [COORD_W-1:0] pix_row;
    logic [COORD_W-1:0] bin_col;
    logic [COORD_W-1:0] bin_row;
    logic [2:0]         col_in_bin;
    logic [2:0]         row_in_bin;
    logic [SUM_W-1:0]   row_sums [MAX_WIDTH];

    // Bins predicted but not yet seen on the output channel, oldest first.
    t_out_item          expected_bins [$];

    // A size of zero behaves as one, and a size above the maximum as the maximum.
    function automatic int unsigned effective_size(input int unsigned v, input int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        o_fail_count = o_fail_count + 1;
        if (o_fail_count <= PRINT_CAP) $display("%0t ns mismatch: %s", $time, msg);
    endtask

    // Advance the position state by one pixel item and queue a bin if it completes one.
    task automatic bin_pixel(input t_in_item px);
        int unsigned       w;
        int unsigned       h;
        int unsigned       bf;
        logic [IDX_W-1:0]  idx;
        logic [CORR_W-1:0] corrected;
        logic [SUM_W:0]    total;
        logic              row_end;
        logic              frame_end;
        logic              col_done;
        logic              row_done;
        t_out_item         bin;
        w  = effective_size(32'(width_reg), MAX_WIDTH);
        h  = effective_size(32'(height_reg), MAX_WIDTH);
        bf = effective_size(32'(bin_reg), MAX_BIN);

        if (px.frame_start) begin
            pix_col    = '0;
            pix_row    = '0;
            col_in_bin = '0;
            row_in_bin = '0;
            bin_col    = '0;
            bin_row    = '0;
        end

        if (mode_reg) begin
            corrected = CORR_W'(px.pixel_value) + CORR_W'(px.pedestal_value);
        end else begin
            corrected = CORR_W'(px.pixel_value) + FIXED_OFFSET;
        end

        // The first pixel of a bin overwrites its store entry; later ones accumulate.
        idx = (32'(bin_col) >= MAX_WIDTH) ? IDX_W'(MAX_WIDTH - 1) : IDX_W'(bin_col);
        if (col_in_bin == 0 && row_in_bin == 0) begin
            total = (SUM_W + 1)'(corrected);
        end else begin
            total = {1'b0, row_sums[idx]} + (SUM_W + 1)'(corrected);
            if (total > (SUM_W + 1)'(SUM_MAX)) total = (SUM_W + 1)'(SUM_MAX);
        end
        row_sums[idx] = total[SUM_W-1:0];

        // Counters at or past the last index of a size end the row, frame or bin.
        row_end   = 32'(pix_col) >= w - 1;
        frame_end = 32'(pix_row) >= h - 1;
        col_done  = row_end || 32'(col_in_bin) >= bf - 1;
        row_done  = frame_end || 32'(row_in_bin) >= bf - 1;

        if (col_done && row_done) begin
            bin.bin_sum    = total[SUM_W-1:0];
            bin.bin_column = bin_col;
            bin.bin_row    = bin_row;
            bin.frame_last = row_end && frame_end;
            expected_bins.insert(expected_bins.size(), bin);
        end

        if (row_end) begin
            pix_col    = '0;
            col_in_bin = '0;
            bin_col    = '0;
            if (frame_end) begin
                pix_row    = '0;
                row_in_bin = '0;
                bin_row    = '0;
            end else begin
                pix_row = pix_row + 1'b1;
                if (row_done) begin
                    row_in_bin = '0;
                    bin_row    = bin_row + 1'b1;
                end else begin
                    row_in_bin = row_in_bin + 1'b1;
                end
            end
        end else begin
            pix_col = pix_col + 1'b1;
            if (col_done) begin
                col_in_bin = '0;
                bin_col    = bin_col + 1'b1;
            end else begin
                col_in_bin = col_in_bin + 1'b1;
            end
        end
    endtask

    // Compare one accepted bin against the oldest prediction.
    task automatic check_bin(input t_out_item got);
        t_out_item want;
        o_bin_count = o_bin_count + 1;
        if (expected_bins.size() == 0) begin
            report_mismatch($sformatf("bin at column %0d row %0d with nothing expected",
                                      got.bin_column, got.bin_row));
            return;
        end
        want = expected_bins.pop_front();
        if (got.bin_sum !== want.bin_sum)
            report_mismatch($sformatf("bin (%0d,%0d) sum %0d, expected %0d",
                                      want.bin_column, want.bin_row, got.bin_sum, want.bin_sum));
        if (got.bin_column !== want.bin_column)
            report_mismatch($sformatf("bin column %0d, expected %0d",
                                      got.bin_column, want.bin_column));
        if (got.bin_row !== want.bin_row)
            report_mismatch($sformatf("bin row %0d, expected %0d", got.bin_row, want.bin_row));
        if (got.frame_last !== want.frame_last)
            report_mismatch($sformatf("bin (%0d,%0d) frame_last %b, expected %b",
                                      want.bin_column, want.bin_row,
                                      got.frame_last, want.frame_last));
    endtask

    // Watch all three channels at each rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = 13'd1024;
            height_reg = 13'd1024;
            bin_reg    = 4'd1;
            mode_reg   = 1'b1;
            pix_col    = '0;
            pix_row    = '0;
            col_in_bin = '0;
            row_in_bin = '0;
            bin_col    = '0;
            bin_row    = '0;
            row_sums   = '{default: '0};
            expected_bins.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FRAME_WIDTH:   width_reg  = i_cfg_data;
                    CFG_FRAME_HEIGHT:  height_reg = i_cfg_data;
                    CFG_BIN_FACTOR:    bin_reg    = i_cfg_data[3:0];
                    CFG_PEDESTAL_MODE: mode_reg   = i_cfg_data[0];
                    default: ;
                endcase
            end
            // Predict before comparing, so a same-edge result still finds its entry.
            if (i_in_valid && !i_in_stall) bin_pixel(i_in_data);
            if (i_out_valid && !i_out_stall) check_bin(i_out_data);
        end
        o_pending <= expected_bins.size();
    end

endmodule

>>> bench/tb.sv
// Top of the pixel binner testbench: clock, reset, stimulus and the final verdict.
`timescale 1ns / 100ps

module tb;
    import pab_pkg::*;

    localparam int LIMIT          = 300000;
    localparam int SETTLE         = 8;
    localparam int MAX_RND_WIDTH  = 48;
    localparam int LONG_HOLD      = 300;
    localparam int PHASES         = 11;
    localparam int PRESSURE_PHASE = 8;
    localparam int PAUSE_PHASE    = 9;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    t_in_item    i_in_data   = '0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [12:0] i_cfg_data  = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out_data;
    logic        o_cfg_ready;

    int fail_count;
    int pending;
    int bins_seen;
    int cycle_count    = 0;
    int items_sent     = 0;
    int configs_done   = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_count     = 0;
    bit hold_enable    = 1'b0;

    pedestal_add_pixel_binning dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    pab_bin_checker u_bin_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .i_in_stall   (o_in_stall),
        .i_out_valid  (o_out_valid),
        .i_out_data   (o_out_data),
        .i_out_stall  (i_out_stall),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_bin_count  (bins_seen)
    );

    always #5 i_clk = ~i_clk;

    // Give up if the run hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Output side: random stall, or one long hold-off when it is enabled.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_count = 0;
        end else if (hold_enable && hold_count < LONG_HOLD) begin
            i_out_stall <= 1'b1;
            hold_count = hold_count + 1;
        end else begin
            if (!hold_enable) hold_count = 0;
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic t_in_item make_pixel(input logic [15:0] value,
                                            input logic [17:0] pedestal,
                                            input logic        start);
        t_in_item px;
        px.pixel_value    = value;
        px.pedestal_value = pedestal;
        px.frame_start    = start;
        return px;
    endfunction

    // Offer one pixel item after a random gap and hold it until accepted.
    task automatic send_pixel(input t_in_item px);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= px;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    task automatic send_random(input logic start);
        send_pixel(make_pixel(16'($urandom_range(16'hFFFF)),
                              18'($urandom_range(18'h3FFFF)), start));
    endtask

    // Valid is left high; the caller lowers it after the last write.
    task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic configure(input logic [12:0] w, input logic [12:0] h,
                             input logic [3:0] bf, input logic mode);
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        write_reg(CFG_BIN_FACTOR, {9'd0, bf});
        write_reg(CFG_PEDESTAL_MODE, {12'd0, mode});
        i_cfg_valid <= 1'b0;
        configs_done++;
    endtask

    // Stop sending until every predicted bin has come out, then let the pipeline settle.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        logic [12:0] w;
        logic [12:0] h;
        logic [3:0]  bf;
        int          count;
        bit          fresh;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 30;
        recv_idle_pct = 73;

        // Register defaults: one-pixel bins in a large frame.
        send_pixel(make_pixel(16'h0000, 18'h00000, 1'b0));
        send_pixel(make_pixel(16'hFFFF, 18'h3FFFF, 1'b0));
        wait_drained();

        // Zero sizes act as one, constant offset mode.
        configure(13'd0, 13'd0, 4'd0, 1'b0);
        send_pixel(make_pixel(16'h0000, 18'h00000, 1'b1));
        send_pixel(make_pixel(16'hFFFF, 18'h3FFFF, 1'b0));
        wait_drained();

        // Oversized values clamp; a partial bin is left behind.
        configure(13'h1FFF, 13'h1FFF, 4'hF, 1'b1);
        send_pixel(make_pixel(16'hFFFF, 18'h3FFFF, 1'b1));
        send_pixel(make_pixel(16'hFFFF, 18'h3FFFF, 1'b0));
        send_pixel(make_pixel(16'h5A5A, 18'h2A5A5, 1'b0));
        wait_drained();

        // Widest frame, single row, restarted by frame_start.
        configure(13'd4096, 13'd1, 4'd1, 1'b1);
        send_pixel(make_pixel(16'h1234, 18'h00001, 1'b1));
        send_pixel(make_pixel(16'hFFFF, 18'h3FFFF, 1'b0));
        send_pixel(make_pixel(16'h0000, 18'h3FFFF, 1'b0));
        wait_drained();

        // A 3x3 frame in 2x2 bins: full, right, bottom and corner edge bins.
        configure(13'd3, 13'd3, 4'd2, 1'b1);
        for (int k = 0; k < 9; k++)
            send_pixel(make_pixel((k % 2) ? 16'hFFFF : 16'h0000,
                                  (k % 2) ? 18'h3FFFF : 18'h00000, k == 0));
        wait_drained();

        // Frame end wraps the counters, so the second frame needs no frame_start.
        configure(13'd2, 13'd1, 4'd8, 1'b0);
        send_pixel(make_pixel(16'hFFFF, 18'h3FFFF, 1'b1));
        send_pixel(make_pixel(16'hFFFF, 18'h00000, 1'b0));
        send_pixel(make_pixel(16'h0001, 18'h3FFFF, 1'b0));
        send_pixel(make_pixel(16'h8000, 18'h20000, 1'b0));
        wait_drained();

        // One full row of one-pixel bins writes every row store entry used below.
        configure(13'(MAX_RND_WIDTH), 13'd1, 4'd1, 1'($urandom_range(1)));
        for (int k = 0; k < MAX_RND_WIDTH; k++) send_random(k == 0);
        wait_drained();

        // Random frames; a phase may begin mid-frame under a new setting.
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase < 4) begin
                send_idle_pct = 30;
                recv_idle_pct = 73;
            end else if (phase < PRESSURE_PHASE) begin
                send_idle_pct = 73;
                recv_idle_pct = 30;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            w  = ($urandom_range(9) == 0) ? 13'd0 : 13'($urandom_range(1, MAX_RND_WIDTH));
            h  = ($urandom_range(9) == 0) ? 13'h1FFF : 13'($urandom_range(0, 7));
            bf = 4'($urandom_range(0, 15));
            if (phase == PRESSURE_PHASE) begin
                // Every pixel closes a bin, so the held output backs up into the input.
                h  = 13'd1;
                bf = 4'd1;
            end
            configure(w, h, bf, 1'($urandom_range(1)));
            if (phase == PRESSURE_PHASE) hold_enable <= 1'b1;
            count = $urandom_range(30, 60);
            fresh = ($urandom_range(9) < 7);
            for (int n = 0; n < count; n++) begin
                if (phase == PAUSE_PHASE && n == count / 2) wait_drained();
                send_random((n == 0 && fresh) || $urandom_range(99) < 3);
            end
            wait_drained();
            hold_enable <= 1'b0;
        end

        $display("Summary: %0d pixel items, %0d bins checked, %0d register settings.",
                 items_sent, bins_seen, configs_done);
        $display("Covered zero and clamped sizes, both offset modes, mid-frame changes, %s",
                 "stray frame starts and a long output hold-off.");
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
